/* rtl/rgb_led_frame_pwm_encoder_top_defines.svh */
// Assertion macros used by the LED frame encoder sequencer.
`ifndef RGB_LED_FRAME_PWM_ENCODER_TOP_DEFINES_SVH
`define RGB_LED_FRAME_PWM_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define RLFPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define RLFPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/rlfpe_pkg.sv */
// Package with the types, codes and constants of the LED frame encoder.
package rlfpe_pkg;

  localparam int LED_COUNT    = 64;
  localparam int BITS_PER_LED = 24;
  localparam int AW           = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LPW          = $clog2(LED_COUNT + 1);

  localparam logic [7:0] DUTY_ONE_RST    = 8'((2 * 90) / 3);
  localparam logic [7:0] DUTY_ZERO_RST   = 8'(90 / 3);
  localparam logic [7:0] RESET_SLOTS_RST = 8'd144;

  // Item operation codes.
  localparam logic [1:0] OP_SET_ONE = 2'd0;
  localparam logic [1:0] OP_SET_ALL = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DUTY_ONE    = 2'd0;
  localparam logic [1:0] CFG_DUTY_ZERO   = 2'd1;
  localparam logic [1:0] CFG_RESET_SLOTS = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  led_index;
    logic [31:0] color;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       slot_valid;
    logic [7:0] duty_value;
    logic       frame_last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] duty_one;
    logic [7:0] duty_zero;
    logic [7:0] reset_slots;
  } cfg_t;

  typedef struct packed {
    logic          we_one;
    logic          we_all;
    logic [AW-1:0] addr;
    logic [23:0]   grb;
  } wr_req_t;

  // Reorders an input color word into the green, red, blue wire order.
  function automatic logic [23:0] to_grb(logic [31:0] c);
    return {c[23:16], c[31:24], c[15:8]};
  endfunction

endpackage

/* rtl/rlfpe_store.sv */
// Color store: one GRB word per LED in a synchronous memory with valid bits.
module rlfpe_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rlfpe_pkg::wr_req_t         wr,
  input  logic [rlfpe_pkg::AW-1:0]   rd_addr,
  output logic [23:0]                rd_color
);
  import rlfpe_pkg::*;

  logic [23:0]          mem [LED_COUNT];
  logic [LED_COUNT-1:0] vld_r;
  logic [23:0]          fill_r;
  logic [23:0]          q_r;
  logic                 qv_r;
  logic                 hit;

  assign hit = wr.we_one && (wr.addr == rd_addr);

  // Data array: one write port, one registered read port with write bypass.
  always_ff @(posedge clk) begin
    if (wr.we_one) begin
      mem[wr.addr] <= wr.grb;
    end
    if (hit) begin
      q_r <= wr.grb;
    end else begin
      q_r <= mem[rd_addr];
    end
  end

  // Entries that were never written since the last fill read as the fill color.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      fill_r <= '0;
      qv_r   <= 1'b0;
    end else if (wr.we_all) begin
      vld_r  <= '0;
      fill_r <= wr.grb;
      qv_r   <= 1'b0;
    end else begin
      if (wr.we_one) begin
        vld_r[wr.addr] <= 1'b1;
      end
      qv_r <= hit | vld_r[rd_addr];
    end
  end

  assign rd_color = qv_r ? q_r : fill_r;

endmodule

/* rtl/rlfpe_seq.sv */
// Frame sequencer: decodes items, walks the LED bits and builds each result.
`include "rgb_led_frame_pwm_encoder_top_defines.svh"

module rlfpe_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  rlfpe_pkg::in_word_t        item,
  input  rlfpe_pkg::cfg_t            cfg,
  input  logic [23:0]                rd_color,
  output rlfpe_pkg::wr_req_t         wr,
  output logic [rlfpe_pkg::AW-1:0]   rd_addr,
  output logic                       head_ready,
  output rlfpe_pkg::out_word_t       res
);
  import rlfpe_pkg::*;

  logic           streaming_r, streaming_nxt;
  logic [LPW-1:0] led_pos_r, led_pos_nxt;
  logic [4:0]     bit_r, bit_nxt;
  logic [7:0]     pad_r, pad_nxt;
  logic [23:0]    cur_r, cur_nxt;
  logic           head_ok_r;
  logic [LPW-1:0] led_inc;
  logic           in_data;

  assign led_inc    = led_pos_r + 1'b1;
  assign in_data    = led_pos_r < LPW'(LED_COUNT);
  // While idle the read port watches LED 0; during a frame it prefetches the next LED.
  assign rd_addr    = streaming_r ? led_inc[AW-1:0] : '0;
  // A running frame never needs LED 0 again, so only an idle sequencer waits on it.
  assign head_ready = head_ok_r | streaming_r;

  always_comb begin
    res           = '0;
    wr.we_one     = 1'b0;
    wr.we_all     = 1'b0;
    wr.addr       = item.led_index[AW-1:0];
    wr.grb        = to_grb(item.color);
    streaming_nxt = streaming_r;
    led_pos_nxt   = led_pos_r;
    bit_nxt       = bit_r;
    pad_nxt       = pad_r;
    cur_nxt       = cur_r;
    res.status    = ST_OK;
    if (acc) begin
      unique case (item.op)
        OP_SET_ONE: begin
          if (streaming_r) begin
            res.status = ST_BUSY;
          end else if ({1'b0, item.led_index} >= 9'(LED_COUNT)) begin
            res.status = ST_RANGE;
          end else begin
            wr.we_one = 1'b1;
          end
        end
        OP_SET_ALL: begin
          if (streaming_r) begin
            res.status = ST_BUSY;
          end else begin
            wr.we_all = 1'b1;
          end
        end
        OP_START: begin
          if (streaming_r) begin
            res.status = ST_BUSY;
          end else begin
            streaming_nxt = 1'b1;
            led_pos_nxt   = '0;
            bit_nxt       = '0;
            pad_nxt       = '0;
            cur_nxt       = rd_color;
          end
        end
        OP_TICK: begin
          if (streaming_r) begin
            res.slot_valid = 1'b1;
            if (in_data) begin
              res.duty_value = cur_r[23] ? cfg.duty_one : cfg.duty_zero;
              if (bit_r == 5'(BITS_PER_LED - 1)) begin
                bit_nxt     = '0;
                led_pos_nxt = led_inc;
                cur_nxt     = rd_color;
                if ((led_pos_r == LPW'(LED_COUNT - 1)) && (cfg.reset_slots == 8'd0)) begin
                  res.frame_last = 1'b1;
                  streaming_nxt  = 1'b0;
                end
              end else begin
                bit_nxt = bit_r + 5'd1;
                cur_nxt = {cur_r[22:0], 1'b0};
              end
            end else begin
              if (({1'b0, pad_r} + 9'd1) >= {1'b0, cfg.reset_slots}) begin
                res.frame_last = 1'b1;
                streaming_nxt  = 1'b0;
              end
              pad_nxt = pad_r + 8'd1;
            end
          end
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      streaming_r <= 1'b0;
      led_pos_r   <= '0;
      bit_r       <= '0;
      pad_r       <= '0;
      head_ok_r   <= 1'b0;
    end else begin
      streaming_r <= streaming_nxt;
      led_pos_r   <= led_pos_nxt;
      bit_r       <= bit_nxt;
      pad_r       <= pad_nxt;
      // The read just issued was for LED 0 exactly when no frame was running.
      head_ok_r   <= ~streaming_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  `RLFPE_ASSERT_NOW(a_bit_range, streaming_r, bit_r < 5'(BITS_PER_LED))
  `RLFPE_ASSERT_NOW(a_pad_on_boundary, streaming_r && !in_data, bit_r == 5'd0)
  `RLFPE_ASSERT_NOW(a_start_head_ok, acc && !streaming_r && (item.op == OP_START), head_ok_r)
  `RLFPE_ASSERT_NEXT(a_start_runs, acc && !streaming_r && (item.op == OP_START), streaming_r)
  `RLFPE_ASSERT_NOW(a_no_write_busy, streaming_r, !wr.we_one && !wr.we_all)

endmodule

/* rtl/rgb_led_frame_pwm_encoder_top.sv */
// Top level of the RGB LED frame PWM encoder with its configuration and output register.
//
// The encoder keeps one color per LED and streams a frame as PWM compare
// values, one per tick word, in green, red, blue order, most significant bit
// first, followed by a run of zero padding slots.
// Input channel: in_valid, in_stall, in_word (op, led_index, color). Every
// accepted word yields exactly one result word on out_valid, out_stall,
// out_word (status, slot_valid, duty_value, frame_last).
// The result is registered: it is in the output register on the edge after
// acceptance. A new word can be taken every cycle while in_stall is low,
// including every tick of a frame, because the next LED's color is prefetched
// from the color memory while the current LED's 24 bits go out. Set all
// clears the per-entry valid bits and records the fill color.
// After reset, and after each frame ends, in_stall is high for a single
// cycle while the read port refetches LED 0, so a start always sees it.
// Reset clears the store to black, stops any frame and loads the register
// defaults. When out_stall holds a result, in_stall rises and the pending
// result waits unchanged. Configuration writes take effect from the next cycle.
module rgb_led_frame_pwm_encoder_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rlfpe_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rlfpe_pkg::out_word_t  out_word,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata
);
  import rlfpe_pkg::*;

  cfg_t                cfg_r;
  logic                acc;
  logic                head_ready;
  logic [AW-1:0]       rd_addr;
  logic [23:0]         rd_color;
  wr_req_t             wr;
  out_word_t           res;
  logic                out_valid_r;
  out_word_t           out_word_r;

  // Take a word when the output register is free or drains this cycle, and
  // the read port holds LED 0 whenever no frame runs.
  assign in_stall = (out_valid_r && out_stall) || !head_ready;
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_one    <= DUTY_ONE_RST;
      cfg_r.duty_zero   <= DUTY_ZERO_RST;
      cfg_r.reset_slots <= RESET_SLOTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DUTY_ONE:    cfg_r.duty_one    <= cfg_wdata;
        CFG_DUTY_ZERO:   cfg_r.duty_zero   <= cfg_wdata;
        CFG_RESET_SLOTS: cfg_r.reset_slots <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  rlfpe_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_color (rd_color)
  );

  rlfpe_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .item       (in_word),
    .cfg        (cfg_r),
    .rd_color   (rd_color),
    .wr         (wr),
    .rd_addr    (rd_addr),
    .head_ready (head_ready),
    .res        (res)
  );

  // Output register: loads on acceptance and empties when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
